// ===== rtl/atr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types, codes, constants and rate tables of the ATR parser.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam logic [5:0] MAX_LENGTH_RESET = 6'd33;
	localparam logic [5:0] BYTE_COUNT_MAX   = 6'd63;
	localparam logic [7:0] TS_DIRECT        = 8'h3B;
	localparam logic [7:0] RATE_DEFAULT     = 8'h11;
	localparam logic [7:0] PTS_FORMAT_BASE  = 8'h10;
	localparam logic [7:0] PTS_CHECK_INIT   = 8'hFF;

	typedef enum logic [2:0] {
		PH_TS    = 3'd0,
		PH_T0    = 3'd1,
		PH_IF    = 3'd2,
		PH_HIST  = 3'd3,
		PH_CHECK = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_TS    = 4'd0,
		ROLE_T0    = 4'd1,
		ROLE_TA    = 4'd2,
		ROLE_TB    = 4'd3,
		ROLE_TC    = 4'd4,
		ROLE_TD    = 4'd5,
		ROLE_HIST  = 4'd6,
		ROLE_CHECK = 4'd7,
		ROLE_NONE  = 4'd8
	} role_t;

	typedef enum logic [2:0] {
		ST_BUSY       = 3'd0,
		ST_OK         = 3'd1,
		ST_INCOMPLETE = 3'd2,
		ST_BAD_CONV   = 3'd3,
		ST_NOT_T0     = 3'd4,
		ST_SPECIFIC   = 3'd5,
		ST_BAD_RATE   = 3'd6,
		ST_TOO_LONG   = 3'd7
	} status_t;

	// parser state seen by the verdict logic
	typedef struct packed {
		phase_t     phase;
		logic [5:0] byte_count;
		logic [3:0] hist_total;
		logic [7:0] conv_byte;
		logic [7:0] format_byte;
		logic [7:0] rate_byte;
		logic [7:0] proto_byte;
		logic       second_ta_seen;
	} atr_state_t;

	typedef struct packed {
		status_t     status;
		role_t       byte_role;
		logic [7:0]  pts_format;
		logic [7:0]  pts_rate;
		logic [7:0]  pts_check;
		logic [11:0] rate_fi;
		logic [6:0]  rate_di;
		logic [11:0] clocks_per_etu;
		logic [3:0]  historical_count;
	} atr_result_t;

	function automatic logic [11:0] fi_lookup(input logic [2:0] idx);
		logic [11:0] fi;
		unique case (idx)
			3'd1:    fi = 12'd512;
			3'd2:    fi = 12'd768;
			3'd3:    fi = 12'd1024;
			3'd4:    fi = 12'd1536;
			3'd5:    fi = 12'd2048;
			default: fi = 12'd0;
		endcase
		return fi;
	endfunction

	// di is a power of two: 0 for code zero, else 1 << (code - 1)
	function automatic logic [6:0] di_lookup(input logic [2:0] idx);
		logic [6:0] di;
		if (idx == 3'd0) begin
			di = 7'd0;
		end else begin
			di = 7'd1 << (idx - 3'd1);
		end
		return di;
	endfunction

endpackage

// ===== rtl/atr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_in_if
// Received-word channel: one ATR byte or an end-of-reception mark.
// ----------------------------------------------------------------------------
interface atr_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== rtl/atr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_out_if
// Result channel: byte role per byte, verdict and PTS request per end mark.
// ----------------------------------------------------------------------------
interface atr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  byte_role;
	logic [7:0]  pts_format;
	logic [7:0]  pts_rate;
	logic [7:0]  pts_check;
	logic [11:0] rate_fi;
	logic [6:0]  rate_di;
	logic [11:0] clocks_per_etu;
	logic [3:0]  historical_count;

	modport source (
		output valid, output status, output byte_role, output pts_format,
		output pts_rate, output pts_check, output rate_fi, output rate_di,
		output clocks_per_etu, output historical_count, input ready
	);
	modport sink (
		input valid, input status, input byte_role, input pts_format,
		input pts_rate, input pts_check, input rate_fi, input rate_di,
		input clocks_per_etu, input historical_count, output ready
	);
endinterface

// ===== rtl/atr_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_parse
// Byte classifier state machine: tracks TS, T0, interface levels 1 and 2,
// historical bytes and the check byte; clears on end of reception.
// ----------------------------------------------------------------------------
module atr_parse import atr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic [5:0] max_length,
	output atr_state_t state,
	output role_t      role,
	output logic [3:0] hist_total_next
);

	phase_t     phase_q, phase_d;
	logic [3:0] mask_q, mask_d;
	logic       lvl2_q, lvl2_d;
	logic [3:0] hist_left_q, hist_left_d;
	logic [3:0] hist_total_q, hist_total_d;
	logic [5:0] byte_count_q, byte_count_d;
	logic [7:0] conv_q, conv_d;
	logic [7:0] format_q, format_d;
	logic [7:0] rate_q, rate_d;
	logic [7:0] proto_q, proto_d;
	logic       second_ta_q, second_ta_d;

	logic [1:0] k;
	logic [3:0] mask_left;
	logic [3:0] mask_new;
	logic       in_range;

	function automatic phase_t after_if(input logic [3:0] mask, input logic [3:0] left);
		phase_t ph;
		if (mask != 4'd0) begin
			ph = PH_IF;
		end else if (left != 4'd0) begin
			ph = PH_HIST;
		end else begin
			ph = PH_CHECK;
		end
		return ph;
	endfunction

	// lowest pending interface byte, TD when only bit 3 is left
	always_comb begin
		priority if (mask_q[0]) begin
			k = 2'd0;
		end else if (mask_q[1]) begin
			k = 2'd1;
		end else if (mask_q[2]) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
	end

	assign mask_left = mask_q & ~(4'b0001 << k);
	assign in_range  = byte_count_q < max_length;

	// next state
	always_comb begin
		phase_d      = phase_q;
		mask_d       = mask_q;
		lvl2_d       = lvl2_q;
		hist_left_d  = hist_left_q;
		hist_total_d = hist_total_q;
		byte_count_d = byte_count_q;
		conv_d       = conv_q;
		format_d     = format_q;
		rate_d       = rate_q;
		proto_d      = proto_q;
		second_ta_d  = second_ta_q;
		mask_new     = mask_left;
		if (accept && kind) begin
			phase_d      = PH_TS;
			mask_d       = 4'd0;
			lvl2_d       = 1'b0;
			hist_left_d  = 4'd0;
			hist_total_d = 4'd0;
			byte_count_d = 6'd0;
			conv_d       = 8'd0;
			format_d     = 8'd0;
			rate_d       = RATE_DEFAULT;
			proto_d      = 8'd0;
			second_ta_d  = 1'b0;
		end else if (accept) begin
			if (byte_count_q != BYTE_COUNT_MAX) begin
				byte_count_d = byte_count_q + 6'd1;
			end
			if (in_range) begin
				unique case (phase_q)
					PH_TS: begin
						conv_d  = rx_byte;
						phase_d = PH_T0;
					end
					PH_T0: begin
						format_d     = rx_byte;
						hist_total_d = rx_byte[3:0];
						hist_left_d  = rx_byte[3:0];
						mask_d       = rx_byte[7:4];
						lvl2_d       = 1'b0;
						phase_d      = after_if(rx_byte[7:4], rx_byte[3:0]);
					end
					PH_IF: begin
						if (k == 2'd0) begin
							if (!lvl2_q) begin
								rate_d = rx_byte;
							end else begin
								second_ta_d = 1'b1;
							end
						end else if (k == 2'd3 && !lvl2_q) begin
							// TD1 announces the level 2 bytes
							proto_d  = rx_byte;
							mask_new = rx_byte[7:4];
							lvl2_d   = 1'b1;
						end
						mask_d  = mask_new;
						phase_d = after_if(mask_new, hist_left_q);
					end
					PH_HIST: begin
						hist_left_d = hist_left_q - 4'd1;
						if (hist_left_q == 4'd1) begin
							phase_d = PH_CHECK;
						end
					end
					PH_CHECK: begin
						phase_d = PH_DONE;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		role = ROLE_NONE;
		if (in_range) begin
			unique case (phase_q)
				PH_TS:    role = ROLE_TS;
				PH_T0:    role = ROLE_T0;
				PH_IF: begin
					unique case (k)
						2'd0:    role = ROLE_TA;
						2'd1:    role = ROLE_TB;
						2'd2:    role = ROLE_TC;
						default: role = ROLE_TD;
					endcase
				end
				PH_HIST:  role = ROLE_HIST;
				PH_CHECK: role = ROLE_CHECK;
				default:  role = ROLE_NONE;
			endcase
		end
	end

	assign hist_total_next = hist_total_d;

	always_comb begin
		state.phase          = phase_q;
		state.byte_count     = byte_count_q;
		state.hist_total     = hist_total_q;
		state.conv_byte      = conv_q;
		state.format_byte    = format_q;
		state.rate_byte      = rate_q;
		state.proto_byte     = proto_q;
		state.second_ta_seen = second_ta_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TS;
			mask_q       <= 4'd0;
			lvl2_q       <= 1'b0;
			hist_left_q  <= 4'd0;
			hist_total_q <= 4'd0;
			byte_count_q <= 6'd0;
			conv_q       <= 8'd0;
			format_q     <= 8'd0;
			rate_q       <= RATE_DEFAULT;
			proto_q      <= 8'd0;
			second_ta_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			mask_q       <= mask_d;
			lvl2_q       <= lvl2_d;
			hist_left_q  <= hist_left_d;
			hist_total_q <= hist_total_d;
			byte_count_q <= byte_count_d;
			conv_q       <= conv_d;
			format_q     <= format_d;
			rate_q       <= rate_d;
			proto_q      <= proto_d;
			second_ta_q  <= second_ta_d;
		end
	end

endmodule

// ===== rtl/atr_verdict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_verdict
// Builds the result word: byte role, or verdict with PTS request and rates.
// ----------------------------------------------------------------------------
module atr_verdict import atr_pkg::*; (
	input  logic        kind,
	input  role_t       role,
	input  logic [3:0]  hist_total_next,
	input  atr_state_t  state,
	input  logic [5:0]  max_length,
	output atr_result_t res
);

	logic [7:0]  fmt;
	logic [11:0] fi;
	logic [6:0]  di;
	logic [2:0]  di_code;
	status_t     verdict;

	assign di_code = state.rate_byte[2:0];
	assign fmt = PTS_FORMAT_BASE |
		(state.format_byte[7] ? {4'd0, state.proto_byte[3:0]} : 8'd0);
	assign fi = fi_lookup(state.rate_byte[6:4]);
	assign di = di_lookup(di_code);

	always_comb begin
		priority if (state.byte_count > max_length) begin
			verdict = ST_TOO_LONG;
		end else if (state.phase != PH_CHECK && state.phase != PH_DONE) begin
			verdict = ST_INCOMPLETE;
		end else if (state.conv_byte != TS_DIRECT) begin
			verdict = ST_BAD_CONV;
		end else if (state.proto_byte[3:0] != 4'd0) begin
			verdict = ST_NOT_T0;
		end else if (state.second_ta_seen) begin
			verdict = ST_SPECIFIC;
		end else if (fi == 12'd0 || di == 7'd0) begin
			verdict = ST_BAD_RATE;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		res = '0;
		if (!kind) begin
			res.status           = ST_BUSY;
			res.byte_role        = role;
			res.historical_count = hist_total_next;
		end else begin
			res.status           = verdict;
			res.byte_role        = ROLE_NONE;
			res.historical_count = state.hist_total;
			if (verdict == ST_OK || verdict == ST_BAD_RATE) begin
				res.pts_format = fmt;
				res.pts_rate   = state.rate_byte;
				res.pts_check  = PTS_CHECK_INIT ^ fmt ^ state.rate_byte;
				res.rate_fi    = fi;
				res.rate_di    = di;
			end
			// di is a power of two, so fi / di is a right shift
			if (verdict == ST_OK) begin
				res.clocks_per_etu = fi >> (di_code - 3'd1);
			end
		end
	end

endmodule

// ===== rtl/smartcard_atr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// Answer-to-reset parser with PTS request build for a T=0 smartcard reader.
// ----------------------------------------------------------------------------
// usage:
//   char_stream carries one word per received ATR byte (kind 0) and one
//   end-of-reception word (kind 1) after the line goes quiet.
//   result returns exactly one word per input word: the byte role for a
//   byte, or the verdict with PTS0/PTS1/PCK, Fi, Di and clocks per ETU for
//   an end mark. After a verdict the parser is ready for a new ATR.
//   cfg_we/cfg_wdata set max_length; write it only while the block is idle.
// result timing and throughput:
//   a result is valid in the cycle after its word is accepted; one word per
//   cycle is taken while the single result register is free or being taken.
// reset:
//   arst_n clears the parser to wait for TS and max_length to 33.
// stall:
//   while result is held, char_stream still takes a word in the cycle the
//   held result is taken; otherwise ready stays low.
// ----------------------------------------------------------------------------
module smartcard_atr_parser import atr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	atr_in_if.sink     char_stream,
	atr_out_if.source  result,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);

	logic        in_acc;
	logic [5:0]  max_length_q;
	logic        out_valid_q;
	atr_result_t res_d;
	atr_result_t res_q;
	atr_state_t  st;
	role_t       role;
	logic [3:0]  hist_next;

	assign char_stream.ready = !out_valid_q || result.ready;
	assign in_acc = char_stream.valid && char_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	atr_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (in_acc),
		.kind            (char_stream.kind),
		.rx_byte         (char_stream.rx_byte),
		.max_length      (max_length_q),
		.state           (st),
		.role            (role),
		.hist_total_next (hist_next)
	);

	atr_verdict u_verdict (
		.kind            (char_stream.kind),
		.role            (role),
		.hist_total_next (hist_next),
		.state           (st),
		.max_length      (max_length_q),
		.res             (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.status           = res_q.status;
	assign result.byte_role        = res_q.byte_role;
	assign result.pts_format       = res_q.pts_format;
	assign result.pts_rate         = res_q.pts_rate;
	assign result.pts_check        = res_q.pts_check;
	assign result.rate_fi          = res_q.rate_fi;
	assign result.rate_di          = res_q.rate_di;
	assign result.clocks_per_etu   = res_q.clocks_per_etu;
	assign result.historical_count = res_q.historical_count;

	// an accepted word always yields a result word next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted word produced no result");

	// an end mark restarts the parser
	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && char_stream.kind) |=> (st.phase == PH_TS && st.byte_count == 6'd0))
		else $error("parser not cleared after verdict");

	// an accepted ATR always has a nonzero ETU length
	a_ok_has_etu: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == ST_OK) |-> (res_q.clocks_per_etu != 12'd0))
		else $error("ok verdict with zero clocks per etu");

	// byte words never carry a verdict
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !char_stream.kind) |=> (res_q.status == ST_BUSY))
		else $error("byte word carried a verdict");

endmodule

// ===== bench/atr_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_result_checker
// Watches both word channels and the max_length write port of the ATR parser.
// It keeps its own copy of the parser state and predicts one result word per
// accepted input word. Each accepted result word is compared field by field
// with the oldest prediction. It counts mismatches and words still awaited.
// ----------------------------------------------------------------------------
module atr_result_checker import atr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	atr_in_if          in_words,
	atr_out_if         out_words,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	output int         fail_count,
	output int         words_awaited
);

	// parser state as the block should hold it
	phase_t     ph;
	logic [3:0] announced;
	logic [1:0] lvl;
	logic [3:0] hist_to_come;
	logic [3:0] hist_announced;
	logic [5:0] seen_count;
	logic [7:0] ts_byte;
	logic [7:0] t0_byte;
	logic [7:0] rate_byte;
	logic [7:0] td1_byte;
	logic       ta2_seen;
	logic [5:0] max_len;

	atr_result_t awaited_results[$];
	atr_result_t due;
	atr_result_t predicted;
	int          results_seen;

	task automatic clear_parser();
		ph = PH_TS;
		announced = 4'h0;
		lvl = 2'd1;
		hist_to_come = 4'h0;
		hist_announced = 4'h0;
		seen_count = 6'd0;
		ts_byte = 8'h00;
		t0_byte = 8'h00;
		rate_byte = RATE_DEFAULT;
		td1_byte = 8'h00;
		ta2_seen = 1'b0;
	endtask

	function automatic phase_t after_iface_phase();
		if (announced != 4'h0) begin
			return PH_IF;
		end else if (hist_to_come != 4'h0) begin
			return PH_HIST;
		end
		return PH_CHECK;
	endfunction

	task automatic predict_word(input logic is_end, input logic [7:0] b,
			output atr_result_t r);
		int          slot;
		logic [7:0]  fmt;
		logic [11:0] fi;
		logic [6:0]  di;
		status_t     st;
		r = '0;
		r.status = ST_BUSY;
		r.byte_role = ROLE_NONE;
		if (!is_end) begin
			// past max_length a byte is counted but not parsed
			if (seen_count < max_len) begin
				case (ph)
					PH_TS: begin
						ts_byte = b;
						ph = PH_T0;
						r.byte_role = ROLE_TS;
					end
					PH_T0: begin
						t0_byte = b;
						hist_announced = b[3:0];
						hist_to_come = b[3:0];
						announced = b[7:4];
						lvl = 2'd1;
						r.byte_role = ROLE_T0;
						ph = after_iface_phase();
					end
					PH_IF: begin
						slot = 0;
						while (slot < 3 && !announced[slot]) slot++;
						announced[slot] = 1'b0;
						r.byte_role = role_t'(ROLE_TA + slot);
						if (slot == 0) begin
							if (lvl == 2'd1) begin
								rate_byte = b;
							end else begin
								ta2_seen = 1'b1;
							end
						end else if (slot == 3 && lvl == 2'd1) begin
							// td1 announces level 2, td2 is not followed
							td1_byte = b;
							announced = b[7:4];
							lvl = 2'd2;
						end
						ph = after_iface_phase();
					end
					PH_HIST: begin
						r.byte_role = ROLE_HIST;
						hist_to_come = hist_to_come - 4'd1;
						if (hist_to_come == 4'h0) ph = PH_CHECK;
					end
					PH_CHECK: begin
						r.byte_role = ROLE_CHECK;
						ph = PH_DONE;
					end
					default: begin
						r.byte_role = ROLE_NONE;
					end
				endcase
			end
			if (seen_count != BYTE_COUNT_MAX) seen_count = seen_count + 6'd1;
			r.historical_count = hist_announced;
			return;
		end

		fmt = PTS_FORMAT_BASE | (t0_byte[7] ? {4'h0, td1_byte[3:0]} : 8'h00);
		case (rate_byte[6:4])
			3'd1:    fi = 12'd512;
			3'd2:    fi = 12'd768;
			3'd3:    fi = 12'd1024;
			3'd4:    fi = 12'd1536;
			3'd5:    fi = 12'd2048;
			default: fi = 12'd0;
		endcase
		case (rate_byte[2:0])
			3'd1:    di = 7'd1;
			3'd2:    di = 7'd2;
			3'd3:    di = 7'd4;
			3'd4:    di = 7'd8;
			3'd5:    di = 7'd16;
			3'd6:    di = 7'd32;
			3'd7:    di = 7'd64;
			default: di = 7'd0;
		endcase

		if (seen_count > max_len) begin
			st = ST_TOO_LONG;
		end else if (ph != PH_CHECK && ph != PH_DONE) begin
			st = ST_INCOMPLETE;
		end else if (ts_byte != TS_DIRECT) begin
			st = ST_BAD_CONV;
		end else if (td1_byte[3:0] != 4'h0) begin
			st = ST_NOT_T0;
		end else if (ta2_seen) begin
			st = ST_SPECIFIC;
		end else if (fi == 12'd0 || di == 7'd0) begin
			st = ST_BAD_RATE;
		end else begin
			st = ST_OK;
		end

		r.status = st;
		if (st == ST_OK || st == ST_BAD_RATE) begin
			r.pts_format = fmt;
			r.pts_rate = rate_byte;
			r.pts_check = PTS_CHECK_INIT ^ fmt ^ rate_byte;
			r.rate_fi = fi;
			r.rate_di = di;
			if (st == ST_OK) r.clocks_per_etu = fi / {5'd0, di};
		end
		r.historical_count = hist_announced;
		clear_parser();
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] result word %0d: %s", $time, results_seen, msg);
		fail_count++;
	endtask

	task automatic check_field(input string field, input logic [11:0] got,
			input logic [11:0] want);
		if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = MAX_LENGTH_RESET;
			clear_parser();
			awaited_results.delete();
			results_seen = 0;
			fail_count = 0;
			words_awaited <= 0;
		end else begin
			if (cfg_we) max_len = cfg_wdata;

			if (out_words.valid && out_words.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("no word awaited, status %0d role %0d",
						out_words.status, out_words.byte_role));
				end else begin
					due = awaited_results.pop_front();
					check_field("status", out_words.status, due.status);
					check_field("byte_role", out_words.byte_role, due.byte_role);
					check_field("pts_format", out_words.pts_format, due.pts_format);
					check_field("pts_rate", out_words.pts_rate, due.pts_rate);
					check_field("pts_check", out_words.pts_check, due.pts_check);
					check_field("rate_fi", out_words.rate_fi, due.rate_fi);
					check_field("rate_di", out_words.rate_di, due.rate_di);
					check_field("clocks_per_etu", out_words.clocks_per_etu, due.clocks_per_etu);
					check_field("historical_count", out_words.historical_count,
						due.historical_count);
				end
				results_seen++;
			end

			if (in_words.valid && in_words.ready) begin
				predict_word(in_words.kind, in_words.rx_byte, predicted);
				awaited_results.push_back(predicted);
			end

			words_awaited <= awaited_results.size();
		end
	end

endmodule

// ===== bench/smartcard_atr_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartcard_atr_parser_tb
// Drives answer-to-reset byte streams and end marks into the parser: a short
// directed set, then random answers (well formed, cut short, overlong, noise)
// over several max_length settings, with random gaps on both channels (none in
// the last setting), two long result stalls and a drain before every register
// write. Checking is done by atr_result_checker.
// ----------------------------------------------------------------------------
module smartcard_atr_parser_tb;
	import atr_pkg::*;

	localparam int   CYCLE_LIMIT = 500000;
	localparam int   HOLD_CYCLES = 150;
	localparam int   PHASE_WORDS = 175;
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_END    = 1'b1;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [5:0] cfg_wdata;
	int         fail_count;
	int         words_awaited;
	int         words_sent;
	int         cycle_count = 0;
	bit         gaps_on;
	int         hold_requests;
	int         holds_done;

	logic [5:0] length_plan [10] = '{6'd33, 6'd2, 6'd63, 6'd0, 6'd12,
		6'd1, 6'd26, 6'd5, 6'd45, 6'd33};

	atr_in_if  in_words();
	atr_out_if out_words();

	smartcard_atr_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_stream(in_words),
		.result(out_words),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	atr_result_checker verdict_watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_words(in_words),
		.out_words(out_words),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.words_awaited(words_awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("smartcard_atr_parser_tb failed");
			$finish;
		end
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// called at a rising edge, returns at the edge where the word is taken
	task automatic send_word(input logic k, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_words.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_words.valid <= 1'b1;
		in_words.kind <= k;
		in_words.rx_byte <= b;
		@(posedge clk);
		while (!in_words.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_atr_bytes(input logic [7:0] bytes[$]);
		foreach (bytes[i]) send_word(KIND_BYTE, bytes[i]);
		send_word(KIND_END, rnd_byte());
	endtask

	task automatic write_max_length(input logic [5:0] v);
		in_words.valid <= 1'b0;
		@(posedge clk);
		while (words_awaited != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_atr();
		logic [7:0] seq[$];
		logic [7:0] t0;
		logic [7:0] ta1;
		logic [7:0] td1;
		int         shape;
		int         n;
		int         i;
		shape = $urandom_range(0, 99);
		if (shape < 7) begin
			// noise words, any kind, no closing mark
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) send_word($urandom_range(0, 3) == 0, rnd_byte());
			return;
		end
		if (shape < 12) begin
			// long run that can saturate the byte counter
			n = $urandom_range(60, 70);
			for (i = 0; i < n; i++) seq.push_back(rnd_byte());
			send_atr_bytes(seq);
			return;
		end

		seq.push_back(($urandom_range(0, 9) == 0) ? rnd_byte() : TS_DIRECT);
		t0 = rnd_byte();
		if ($urandom_range(0, 1) == 0) t0[3:0] = 4'($urandom_range(0, 3));
		seq.push_back(t0);
		if (t0[4]) begin
			ta1 = rnd_byte();
			if ($urandom_range(0, 4) != 0) begin
				ta1[6:4] = 3'($urandom_range(1, 5));
				ta1[2:0] = 3'($urandom_range(1, 7));
			end
			seq.push_back(ta1);
		end
		if (t0[5]) seq.push_back(rnd_byte());
		if (t0[6]) seq.push_back(rnd_byte());
		if (t0[7]) begin
			td1 = rnd_byte();
			if ($urandom_range(0, 3) != 0) td1[3:0] = 4'h0;
			if ($urandom_range(0, 2) != 0) td1[4] = 1'b0;
			seq.push_back(td1);
			for (i = 4; i < 8; i++) if (td1[i]) seq.push_back(rnd_byte());
		end
		for (i = 0; i < t0[3:0]; i++) seq.push_back(rnd_byte());
		// check byte is optional
		if ($urandom_range(0, 1) == 0) seq.push_back(rnd_byte());

		if (shape < 22) begin
			n = $urandom_range(0, seq.size() - 1);
			while (seq.size() > n) void'(seq.pop_back());
		end else if (shape < 30) begin
			repeat ($urandom_range(1, 6)) seq.push_back(rnd_byte());
		end
		send_atr_bytes(seq);
	endtask

	// result side: random stalls, plus one long hold-off per request
	initial begin
		out_words.ready = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests > holds_done) begin
				out_words.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				out_words.ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_words.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_words.ready <= 1'b1;
			end else begin
				out_words.ready <= 1'b1;
			end
		end
	end

	initial begin
		int target;
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MAX_LENGTH_RESET;
		in_words.valid = 1'b0;
		in_words.kind = KIND_BYTE;
		in_words.rx_byte = 8'h00;
		gaps_on = 1'b1;
		hold_requests = 0;
		words_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// end mark with nothing received
		send_word(KIND_END, 8'hFF);
		// minimal answer, rate defaults to 0x11
		send_atr_bytes('{8'h3B, 8'h00});
		// all level 1 bytes, highest Fi and Di codes, one historical, check, extra byte
		send_atr_bytes('{8'h3B, 8'hF1, 8'h57, 8'h20, 8'h30, 8'h00, 8'hAB, 8'h4C, 8'h99});
		// ta2 present
		send_atr_bytes('{8'h3B, 8'h80, 8'h10, 8'hFF});
		// unsupported rate codes
		send_atr_bytes('{8'h3B, 8'h10, 8'h00});

		for (p = 0; p < 10; p++) begin
			write_max_length(length_plan[p]);
			if (p == 2 || p == 6) hold_requests++;
			if (p == 9) gaps_on = 1'b0;
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) send_atr();
		end

		in_words.valid <= 1'b0;
		@(posedge clk);
		while (words_awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("smartcard_atr_parser_tb passed");
		end else begin
			$display("smartcard_atr_parser_tb failed");
		end
		$finish;
	end

endmodule
